FILE: src/linear_probe_hash_table_unit_assert.svh
// Assertion macros used by the checker of this block.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpht assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpht assertion failed");

`endif

FILE: src/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

	// Slot count; a power of two, so the start slot is the low key bits.
	localparam int TABLE_SIZE = 32;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int SLOT_W     = 5;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture request, read start slot
		logic probe;   // step to next slot, read it
		logic finish;  // load result, write slot on insert unless table full
	} lpht_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic stop;    // slot just read is empty or holds the key
		logic last;    // slot just read closes a full pass
	} lpht_stat_t;

endpackage

FILE: src/lpht_if.sv
`timescale 1ns / 1ps

interface lpht_req_if import lpht_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [KEY_W-1:0] key_hash;
	logic [VAL_W-1:0] value;

	modport source (output valid, opcode, key_hash, value, input ready);
	modport sink   (input valid, opcode, key_hash, value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  found_value;
	logic [SLOT_W-1:0] slot_index;
	logic              key_matched;
	logic              table_full;

	modport source (output valid, found_value, slot_index, key_matched, table_full,
		input ready);
	modport sink   (input valid, found_value, slot_index, key_matched, table_full,
		output ready);
endinterface

FILE: src/lpht_ctrl.sv
`timescale 1ns / 1ps

module lpht_ctrl import lpht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  lpht_stat_t stat,
	output lpht_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_PROBE = 2'b10
	} lpht_state_t;

	lpht_state_t state_q, state_d;
	logic        rsp_valid_q;
	logic        out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (stat.stop || stat.last) begin
					// hold the read data until the output slot frees up
					if (out_free) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.probe = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

FILE: src/lpht_dp.sv
`timescale 1ns / 1ps

module lpht_dp import lpht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lpht_cmd_t         cmd,
	output lpht_stat_t        stat,
	input  logic              opcode,
	input  logic [KEY_W-1:0]  key_hash,
	input  logic [VAL_W-1:0]  value,
	output logic [VAL_W-1:0]  found_value,
	output logic [SLOT_W-1:0] slot_index,
	output logic              key_matched,
	output logic              table_full
);

	// slot store; contents undefined until the slot's valid bit is set
	logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
	logic [VAL_W-1:0]      val_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] slot_vld_q;

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] next_pos;
	logic [IDX_W-1:0] rd_addr;

	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;
	logic             rd_vld_q;

	logic slot_empty;
	logic key_eq;

	assign next_pos = (pos_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos_q + 1'b1;
	assign rd_addr  = cmd.load ? key_hash[IDX_W-1:0] : next_pos;

	assign slot_empty = !rd_vld_q || (rd_val_q == '0);
	assign key_eq     = (rd_key_q == key_q);
	assign stat.stop  = slot_empty || key_eq;
	assign stat.last  = (cnt_q == IDX_W'(TABLE_SIZE - 1));

	// request capture, probe pointer, registered slot read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			key_q <= key_hash;
			val_q <= value;
			pos_q <= key_hash[IDX_W-1:0];
			cnt_q <= '0;
		end else if (cmd.probe) begin
			pos_q <= next_pos;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.load || cmd.probe) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
			rd_vld_q <= slot_vld_q[rd_addr];
		end
	end

	// slot write on insert, only when probing stopped
	always_ff @(posedge clk) begin
		if (cmd.finish && stat.stop && (op_q == OP_INSERT)) begin
			key_mem[pos_q] <= key_q;
			val_mem[pos_q] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slot_vld_q <= '0;
		else if (cmd.finish && stat.stop && (op_q == OP_INSERT))
			slot_vld_q[pos_q] <= 1'b1;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (stat.stop) begin
				found_value <= slot_empty ? '0 : rd_val_q;
				slot_index  <= SLOT_W'(pos_q);
				key_matched <= !slot_empty && key_eq;
				table_full  <= 1'b0;
			end else begin
				found_value <= '0;
				slot_index  <= SLOT_W'(key_q[IDX_W-1:0]);
				key_matched <= 1'b0;
				table_full  <= 1'b1;
			end
		end
	end

endmodule

FILE: src/linear_probe_hash_table_unit.sv
// The result is registered once probing stops; 1 to 32 slots are probed per request.
// One slot read per cycle from the slot store while probing; a new request waits until the last is finished.
// A result waiting in the output register holds the next request in probe until it is taken.
// Reset (arst_n low) clears the per-slot valid bits at once: the table reads empty
// right after reset, with no clearing pass. Controller and output valid also reset.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit import lpht_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);

	// Flow per request:
	//   idle  : take item, latch it, read start slot (key low bits)
	//   probe : check registered slot data; stop on empty or equal key,
	//           else step forward (wrapping) and read next slot.
	//           A full pass with no stop reports table_full and writes nothing.
	//   on stop, once the output register is free, the result is loaded into it and
	//   an insert writes key and value into the stopping slot in the same cycle.

	lpht_cmd_t  cmd;
	lpht_stat_t stat;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lpht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (req.opcode),
		.key_hash    (req.key_hash),
		.value       (req.value),
		.found_value (rsp.found_value),
		.slot_index  (rsp.slot_index),
		.key_matched (rsp.key_matched),
		.table_full  (rsp.table_full)
	);

endmodule

FILE: src/lpht_checker.sv
`timescale 1ns / 1ps
`include "linear_probe_hash_table_unit_assert.svh"

module lpht_checker import lpht_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [VAL_W-1:0]  found_value,
	input logic [SLOT_W-1:0] slot_index,
	input logic              key_matched,
	input logic              table_full
);

	// a stalled item holds its valid and payload
	`LPHT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(found_value) && $stable(slot_index) && $stable(key_matched) && $stable(table_full))

	// one request in flight: no back-to-back accept
	`LPHT_ASSERT_NEXT(a_one_inflight, clk, arst_n, req_valid && req_ready, !req_ready)

	// a full table reports nothing found
	`LPHT_ASSERT_NOW(a_full_empty, clk, arst_n, rsp_valid && table_full, found_value == '0 && !key_matched)

	// a match always comes from an occupied slot
	`LPHT_ASSERT_NOW(a_match_nonzero, clk, arst_n, rsp_valid && key_matched, found_value != '0)

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.found_value (rsp.found_value),
	.slot_index  (rsp.slot_index),
	.key_matched (rsp.key_matched),
	.table_full  (rsp.table_full)
);
